### rtl/dge_pkg.sv
`default_nettype none
package dge_pkg;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_SWP_RD,
      ST_SWP_WAIT,
      ST_SWP_WR,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_DIV,
      ST_UPD_RD,
      ST_UPD_WAIT,
      ST_UPD_MUL,
      ST_UPD_WR,
      ST_DIAG_RD,
      ST_DIAG_WAIT,
      ST_DIAG_MUL,
      ST_DONE,
      ST_SING
   } state_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic       load_wr;     // write incoming entry at load address
      logic       cap_a;       // capture RAM read data into operand A
      logic       cap_b;       // capture RAM read data into operand B
      logic       div_start;   // start quotient B / A, result into factor
      logic       mul_start;   // start product B * factor (row update)
      logic       acc_start;   // start product acc * A
      logic       wr_upd;      // write A - product at write address
      logic       wr_a;        // write operand A at write address
      logic       wr_b;        // write operand B at write address
      logic       clear_acc;   // reset accumulator, flags
      logic       flip_sign;   // toggle sign flag
      logic       emit;        // present result
      logic       emit_sing;   // present singular result
   } cmd_type;

   typedef struct packed {
      logic a_zero;
      logic div_busy;
      logic mul_busy;
   } status_type;

   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;

   function automatic logic [63:0] mag64(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

endpackage
`default_nettype wire

### rtl/dge_ram.sv
`default_nettype none
module dge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/dge_mul.sv
`default_nettype none
// Q32.32 multiply with saturation, one 32x32 partial product per cycle.
module dge_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             busy,
   output logic             done,
   output logic [63:0]      result,
   output logic             sat
);
   logic [63:0]  am_ff, am_in, bm_ff, bm_in;
   logic         neg_ff, neg_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [63:0]  p_ff, p_in;
   logic [129:0] acc_ff, acc_in;
   logic [31:0]  xa, xb;
   logic [63:0]  mag;
   logic         over;

   always_comb begin
      xa = step_ff[0] ? am_ff[63:32] : am_ff[31:0];
      xb = step_ff[1] ? bm_ff[63:32] : bm_ff[31:0];
   end

   always_comb begin
      am_in = am_ff; bm_in = bm_ff; neg_in = neg_ff;
      step_in = step_ff; busy_in = busy_ff;
      p_in = 64'(xa) * 64'(xb);
      acc_in = acc_ff;
      done = 1'b0;
      if (start) begin
         am_in = dge_pkg::mag64(op_a);
         bm_in = dge_pkg::mag64(op_b);
         neg_in = op_a[63] ^ op_b[63];
         step_in = 3'd0; busy_in = 1'b1; acc_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         if (step_ff != 3'd0) begin
            case (step_ff - 3'd1)
               3'd0: acc_in = acc_ff + 130'(p_ff);
               3'd1, 3'd2: acc_in = acc_ff + (130'(p_ff) << 32);
               default: acc_in = acc_ff + (130'(p_ff) << 64);
            endcase
         end
         if (step_ff == 3'd4) begin
            busy_in = 1'b0; done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; step_ff <= '0;
      end else begin
         busy_ff <= busy_in; step_ff <= step_in;
      end
      am_ff <= am_in; bm_ff <= bm_in; neg_ff <= neg_in;
      p_ff <= p_in; acc_ff <= acc_in;
   end

   // done is combinational on the final accumulate, so form the result from acc_in.
   always_comb begin
      mag  = acc_in[95:32];
      over = (acc_in[129:96] != '0) ||
             (neg_ff ? (mag > dge_pkg::MIN_S64) : (mag > dge_pkg::MAX_S64));
      if (over) result = neg_ff ? dge_pkg::MIN_S64 : dge_pkg::MAX_S64;
      else      result = neg_ff ? (64'd0 - mag) : mag;
      sat = over;
   end
   assign busy = busy_ff;
endmodule
`default_nettype wire

### rtl/dge_div.sv
`default_nettype none
// Q32.32 restoring divider, one quotient bit per cycle.
module dge_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             busy,
   output logic             done,
   output logic [63:0]      result,
   output logic             sat
);
   logic [63:0] rem_ff, rem_in, lo_ff, lo_in, q_ff, q_in, d_ff, d_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in, busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] sh;
   logic [63:0] am, dm, qf;
   logic        over;

   always_comb begin
      rem_in = rem_ff; lo_in = lo_ff; q_in = q_ff; d_in = d_ff;
      neg_in = neg_ff; ovf_in = ovf_ff; busy_in = busy_ff; cnt_in = cnt_ff;
      done = 1'b0;
      am = dge_pkg::mag64(op_a);
      dm = dge_pkg::mag64(op_b);
      sh = {rem_ff, lo_ff[63]};
      if (start) begin
         rem_in = {32'd0, am[63:32]};
         lo_in  = {am[31:0], 32'd0};
         d_in = dm; q_in = '0;
         neg_in = op_a[63] ^ op_b[63];
         ovf_in = ({32'd0, am[63:32]} >= dm);
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         lo_in = lo_ff << 1;
         if (sh >= {1'b0, d_ff}) begin
            rem_in = 64'(sh - {1'b0, d_ff});
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = sh[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63 || ovf_ff) begin
            busy_in = 1'b0; done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      rem_ff <= rem_in; lo_ff <= lo_in; q_ff <= q_in; d_ff <= d_in;
      neg_ff <= neg_in; ovf_ff <= ovf_in; cnt_ff <= cnt_in;
   end

   always_comb begin
      qf = q_in;
      over = ovf_ff || (neg_ff ? (qf > dge_pkg::MIN_S64) : (qf > dge_pkg::MAX_S64));
      if (over) result = neg_ff ? dge_pkg::MIN_S64 : dge_pkg::MAX_S64;
      else      result = neg_ff ? (64'd0 - qf) : qf;
      sat = over;
   end
   assign busy = busy_ff;
endmodule
`default_nettype wire

### rtl/dge_datapath.sv
`default_nettype none
module dge_datapath #(
   parameter int N = 4,
   localparam int CELLS = N * N,
   localparam int AW = $clog2(CELLS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dge_pkg::cmd_type     cmd,
   input  wire logic [AW-1:0]        rd_addr,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic signed [31:0]   entry_value,
   output dge_pkg::status_type       status,
   output logic                      div_done,
   output logic                      mul_done,
   output logic                      rsp_valid,
   output logic signed [63:0]        rsp_determinant,
   output logic                      rsp_singular,
   output logic                      rsp_saturated
);
   logic [63:0] rd_data, wr_data;
   logic        wr_en;
   logic [63:0] a_ff, b_ff, f_ff, acc_ff, prod_ff;
   logic        sat_ff, sat_in, flip_ff;
   logic [63:0] diff, mul_res, div_res, acc_in, detv;
   logic        mul_sat, div_sat, sub_ovf, acc_mode_ff;
   logic        mul_busy, div_busy;
   logic        vout_ff;
   logic [63:0] det_ff;
   logic        sing_ff, rsat_ff;

   dge_ram #(.WIDTH(64), .DEPTH(CELLS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   dge_mul u_mul (
      .clock(clock), .reset(reset), .start(cmd.mul_start | cmd.acc_start),
      .op_a(cmd.acc_start ? acc_ff : b_ff), .op_b(cmd.acc_start ? a_ff : f_ff),
      .busy(mul_busy), .done(mul_done), .result(mul_res), .sat(mul_sat));

   dge_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .op_a(b_ff), .op_b(a_ff),
      .busy(div_busy), .done(div_done), .result(div_res), .sat(div_sat));

   always_comb begin
      diff = a_ff - prod_ff;
      sub_ovf = (a_ff[63] ^ prod_ff[63]) & (a_ff[63] ^ diff[63]);
      wr_en = cmd.load_wr | cmd.wr_upd | cmd.wr_a | cmd.wr_b;
      if (cmd.load_wr)
         wr_data = {{16{entry_value[31]}}, entry_value, 16'd0};
      else if (cmd.wr_upd)
         wr_data = sub_ovf ? (a_ff[63] ? dge_pkg::MIN_S64 : dge_pkg::MAX_S64) : diff;
      else if (cmd.wr_a)
         wr_data = a_ff;
      else
         wr_data = b_ff;
      sat_in = sat_ff | (cmd.wr_upd & sub_ovf) | (mul_done & mul_sat) |
               (div_done & div_sat);
      acc_in = (mul_done & acc_mode_ff) ? mul_res : acc_ff;
      detv = acc_ff;
      if (flip_ff) detv = (acc_ff == dge_pkg::MIN_S64) ? dge_pkg::MAX_S64 : 64'd0 - acc_ff;
   end

   assign status = {(a_ff == '0), div_busy, mul_busy};

   always_ff @(posedge clock) begin
      if (cmd.cap_a) a_ff <= rd_data;
      if (cmd.cap_b) b_ff <= rd_data;
      if (div_done) f_ff <= div_res;
      if (mul_done && !acc_mode_ff) prod_ff <= mul_res;
      if (cmd.mul_start) acc_mode_ff <= 1'b0;
      if (cmd.acc_start) acc_mode_ff <= 1'b1;
      det_ff <= cmd.emit_sing ? 64'd0 : detv;
      sing_ff <= cmd.emit_sing;
      rsat_ff <= sat_ff | (cmd.emit & flip_ff & (acc_ff == dge_pkg::MIN_S64));
      if (reset) begin
         acc_ff <= dge_pkg::ONE_Q32; sat_ff <= 1'b0; flip_ff <= 1'b0; vout_ff <= 1'b0;
      end else begin
         vout_ff <= cmd.emit | cmd.emit_sing;
         if (cmd.clear_acc) begin
            acc_ff <= dge_pkg::ONE_Q32; sat_ff <= 1'b0; flip_ff <= 1'b0;
         end else begin
            acc_ff <= acc_in; sat_ff <= sat_in;
            if (cmd.flip_sign) flip_ff <= ~flip_ff;
         end
      end
   end

   assign rsp_valid = vout_ff;
   assign rsp_determinant = det_ff;
   assign rsp_singular = sing_ff;
   assign rsp_saturated = rsat_ff;

`ifndef SYNTH
   a_mul_div_excl: assert property (@(posedge clock) disable iff (reset)
      !(status.mul_busy && status.div_busy))
      else $error("multiplier and divider busy together");
   a_emit_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held more than one cycle");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_determinant == 64'd0))
      else $error("singular result not zero");
`endif
endmodule
`default_nettype wire

### rtl/dge_ctrl.sv
`default_nettype none
module dge_ctrl #(
   parameter int N = 4,
   localparam int CELLS = N * N,
   localparam int AW = $clog2(CELLS),
   localparam int IW = $clog2(N)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire dge_pkg::status_type status,
   input  wire logic                div_done,
   input  wire logic                mul_done,
   output logic                     busy,
   output dge_pkg::cmd_type         cmd,
   output logic [AW-1:0]            rd_addr,
   output logic [AW-1:0]            wr_addr
);
   dge_pkg::state_type state_ff, state_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic [IW:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   function automatic logic [AW-1:0] addr(input logic [IW:0] r, input logic [IW:0] c);
      return AW'(r[IW-1:0] * N + c[IW-1:0]);
   endfunction

   // Next state and loop counters.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff; i_in = i_ff; j_in = j_ff; k_in = k_ff;
      case (state_ff)
         dge_pkg::ST_LOAD: begin
            if (start) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == (AW+1)'(CELLS - 1)) begin
                  cnt_in = '0; i_in = '0; state_in = dge_pkg::ST_PIV_RD;
               end
            end
         end
         dge_pkg::ST_PIV_RD: state_in = dge_pkg::ST_PIV_CHK;
         dge_pkg::ST_PIV_CHK: begin
            // The pivot read data is captured into a on the edge that ends this state.
            state_in = dge_pkg::ST_SRCH_CHK;
            j_in = i_ff + 1'b1;
         end
         dge_pkg::ST_SRCH_CHK: begin
            if (!status.a_zero) begin
               j_in = i_ff + 1'b1; state_in = dge_pkg::ST_ROW_RD;
            end else if (j_ff == (IW+1)'(N)) state_in = dge_pkg::ST_SING;
            else state_in = dge_pkg::ST_SRCH_RD;
         end
         dge_pkg::ST_SRCH_RD: state_in = dge_pkg::ST_SWP_WAIT;
         dge_pkg::ST_SWP_WAIT: begin
            // The candidate is captured into a and then tested;
            // if nonzero, rows i and j are swapped.
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(1)) begin
               cnt_in = '0;
               if (!status.a_zero) begin
                  k_in = '0; state_in = dge_pkg::ST_SWP_RD;
               end else begin
                  j_in = j_ff + 1'b1;
                  state_in = (j_ff + 1'b1 == (IW+1)'(N)) ? dge_pkg::ST_SING
                                                         : dge_pkg::ST_SRCH_RD;
               end
            end
         end
         dge_pkg::ST_SWP_RD: state_in = dge_pkg::ST_SWP_WR;   // read row i -> a
         dge_pkg::ST_SWP_WR: begin
            // cnt 0: capture a, read j; 1: capture b; 2: write a to j; 3: write b to i
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(3)) begin
               cnt_in = '0;
               k_in = k_ff + 1'b1;
               state_in = (k_ff + 1'b1 == (IW+1)'(N)) ? dge_pkg::ST_PIV_RD
                                                      : dge_pkg::ST_SWP_RD;
            end
         end
         dge_pkg::ST_ROW_RD: begin
            if (j_ff == (IW+1)'(N)) begin
               i_in = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == (IW+1)'(N)) ? dge_pkg::ST_DIAG_RD
                                                      : dge_pkg::ST_PIV_RD;
               k_in = '0;
            end else state_in = dge_pkg::ST_ROW_WAIT;
         end
         dge_pkg::ST_ROW_WAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(2)) begin
               cnt_in = '0; state_in = dge_pkg::ST_DIV;
            end
         end
         dge_pkg::ST_DIV: begin
            if (div_done) begin
               k_in = i_ff + 1'b1; state_in = dge_pkg::ST_UPD_RD;
            end
         end
         dge_pkg::ST_UPD_RD: begin
            if (k_ff == (IW+1)'(N)) begin
               j_in = j_ff + 1'b1; state_in = dge_pkg::ST_ROW_RD;
            end else state_in = dge_pkg::ST_UPD_WAIT;
         end
         dge_pkg::ST_UPD_WAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(3)) begin
               cnt_in = '0; state_in = dge_pkg::ST_UPD_MUL;
            end
         end
         dge_pkg::ST_UPD_MUL: begin
            if (mul_done) state_in = dge_pkg::ST_UPD_WR;
         end
         dge_pkg::ST_UPD_WR: begin
            k_in = k_ff + 1'b1; state_in = dge_pkg::ST_UPD_RD;
         end
         dge_pkg::ST_DIAG_RD: begin
            if (k_ff == (IW+1)'(N)) state_in = dge_pkg::ST_DONE;
            else state_in = dge_pkg::ST_DIAG_WAIT;
         end
         dge_pkg::ST_DIAG_WAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AW+1)'(1)) begin
               cnt_in = '0; state_in = dge_pkg::ST_DIAG_MUL;
            end
         end
         dge_pkg::ST_DIAG_MUL: begin
            if (mul_done) begin
               k_in = k_ff + 1'b1; state_in = dge_pkg::ST_DIAG_RD;
            end
         end
         dge_pkg::ST_DONE: state_in = dge_pkg::ST_LOAD;
         dge_pkg::ST_SING: state_in = dge_pkg::ST_LOAD;
         default: state_in = dge_pkg::ST_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      rd_addr = addr(i_ff, i_ff);
      wr_addr = cnt_ff[AW-1:0];
      busy = (state_ff != dge_pkg::ST_LOAD);
      case (state_ff)
         dge_pkg::ST_LOAD: cmd.load_wr = start;
         dge_pkg::ST_PIV_RD: rd_addr = addr(i_ff, i_ff);
         dge_pkg::ST_PIV_CHK: cmd.cap_a = 1'b1;
         dge_pkg::ST_SRCH_CHK: ;
         dge_pkg::ST_SRCH_RD: rd_addr = addr(j_ff, i_ff);
         dge_pkg::ST_SWP_WAIT: cmd.cap_a = ~cnt_ff[0];
         dge_pkg::ST_SWP_RD: rd_addr = addr(i_ff, k_ff);
         dge_pkg::ST_SWP_WR: begin
            case (cnt_ff[1:0])
               2'd0: begin cmd.cap_a = 1'b1; rd_addr = addr(j_ff, k_ff); end
               2'd1: cmd.cap_b = 1'b1;
               2'd2: begin cmd.wr_a = 1'b1; wr_addr = addr(j_ff, k_ff); end
               default: begin
                  cmd.wr_b = 1'b1; wr_addr = addr(i_ff, k_ff);
                  cmd.flip_sign = (k_ff + 1'b1 == (IW+1)'(N));
               end
            endcase
         end
         dge_pkg::ST_ROW_RD: rd_addr = addr(i_ff, i_ff);
         dge_pkg::ST_ROW_WAIT: begin
            // 0: capture pivot into a, read row entry; 1: capture into b; 2: start divide
            case (cnt_ff[1:0])
               2'd0: begin cmd.cap_a = 1'b1; rd_addr = addr(j_ff, i_ff); end
               2'd1: cmd.cap_b = 1'b1;
               default: cmd.div_start = 1'b1;
            endcase
         end
         dge_pkg::ST_DIV: ;
         dge_pkg::ST_UPD_RD: begin
            rd_addr = addr(i_ff, k_ff);
            if (k_ff == (IW+1)'(N)) begin
               cmd.wr_b = 1'b0;
            end
         end
         dge_pkg::ST_UPD_WAIT: begin
            // 0: b <- piv[k], read row[k]; 1: a <- row[k]; 2: start mul; 3: wait
            case (cnt_ff[1:0])
               2'd0: begin cmd.cap_b = 1'b1; rd_addr = addr(j_ff, k_ff); end
               2'd1: cmd.cap_a = 1'b1;
               2'd2: cmd.mul_start = 1'b1;
               default: ;
            endcase
         end
         dge_pkg::ST_UPD_MUL: ;
         dge_pkg::ST_UPD_WR: begin
            cmd.wr_upd = 1'b1; wr_addr = addr(j_ff, k_ff);
         end
         dge_pkg::ST_DIAG_RD: rd_addr = addr(k_ff, k_ff);
         dge_pkg::ST_DIAG_WAIT: begin
            if (cnt_ff[0]) cmd.acc_start = 1'b1;
            else cmd.cap_a = 1'b1;
         end
         dge_pkg::ST_DIAG_MUL: ;
         // The result registers sample the old accumulator and flags on the
         // same edge that returns them to their reset values.
         dge_pkg::ST_DONE: begin cmd.emit = 1'b1; cmd.clear_acc = 1'b1; end
         dge_pkg::ST_SING: begin cmd.emit_sing = 1'b1; cmd.clear_acc = 1'b1; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dge_pkg::ST_LOAD;
         cnt_ff <= '0; i_ff <= '0; j_ff <= '0; k_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      end
   end

`ifndef SYNTH
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dge_pkg::ST_LOAD) |-> !busy)
      else $error("busy while loading");
   a_done_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dge_pkg::ST_DONE) |=> (state_ff == dge_pkg::ST_LOAD))
      else $error("no return to load after result");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dge_pkg::ST_DIV) |-> status.div_busy)
      else $error("waiting on idle divider");
`endif
endmodule
`default_nettype wire

### rtl/determinant_gauss_elimination_core.sv
`default_nettype none
// Determinant by Gaussian elimination on Q32.32 working values.
// Loading takes one request per cycle while busy is low; the divider and the
// multiplier take turns, never running together, and the elimination waits on each.
// Row swaps and zero candidate rows add to the work. One matrix is in work at a
// time, so the next matrix is taken only after the result of the last has been
// shown. Reset (synchronous) empties the load count and clears the flags.
module determinant_gauss_elimination_core #(
   parameter int MATRIX_SIZE = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_entry_value,
   output logic                    rsp_valid,
   output logic signed [63:0]      rsp_determinant,
   output logic                    rsp_singular,
   output logic                    rsp_saturated
);
   localparam int AW = $clog2(MATRIX_SIZE * MATRIX_SIZE);

   dge_pkg::cmd_type    cmd;
   dge_pkg::status_type status;
   logic                div_done, mul_done;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                ctrl_busy;
   logic                req_accept;

   // Only a request taken at the port reaches the controller.
   assign req_accept = start & ~busy;

   // The controller walks the elimination; the datapath owns the store
   // and the arithmetic units.
   dge_ctrl #(.N(MATRIX_SIZE)) u_ctrl (
      .clock(clock), .reset(reset), .start(req_accept), .status(status),
      .div_done(div_done), .mul_done(mul_done), .busy(ctrl_busy),
      .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr));

   dge_datapath #(.N(MATRIX_SIZE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .rd_addr(rd_addr),
      .wr_addr(wr_addr), .entry_value(req_entry_value), .status(status),
      .div_done(div_done), .mul_done(mul_done), .rsp_valid(rsp_valid),
      .rsp_determinant(rsp_determinant), .rsp_singular(rsp_singular),
      .rsp_saturated(rsp_saturated));

   // Hold off the next request until the previous result has been shown, so
   // flags are cleared before the next matrix completes.
   assign busy = ctrl_busy | rsp_valid;
endmodule
`default_nettype wire
